// ===== sv/lhp_pkg.sv =====
// ----------------------------------------------------------------------------
// lhp_pkg: shared types and constants of the latency histogram
// widths, bucket geometry, operation codes and the walk unit control bundle
// ----------------------------------------------------------------------------
package lhp_pkg;

  // histogram geometry
  localparam int NUM_BUCKETS     = 500;
  localparam int BUCKET_WIDTH_US = 10;
  localparam int BKT_W           = $clog2(NUM_BUCKETS);

  // field widths
  localparam int CNT_W  = 32;
  localparam int LAT_W  = 32;
  localparam int FUNC_W = 3;
  localparam int PM_W   = 10;
  localparam int PCT_W  = 13;
  localparam int CFG_AW = 2;

  // per mille scale, running sums of the percentile passes are kept multiplied by it
  localparam int PM_SCALE = 1000;
  localparam int ACC_W    = CNT_W + BKT_W + $clog2(PM_SCALE) + 1;

  // bucket index by reciprocal multiply, exact below the clamp limit
  localparam longint LAT_LIMIT = longint'(NUM_BUCKETS) * longint'(BUCKET_WIDTH_US);
  localparam int     LX_W      = $clog2(LAT_LIMIT);
  localparam int     RSH       = LX_W + $clog2(BUCKET_WIDTH_US);
  localparam longint RECIP     = ((64'd1 << RSH) + BUCKET_WIDTH_US - 1) / BUCKET_WIDTH_US;

  // bucket edge product width
  localparam int EDGE_PW = BKT_W + 1 + $clog2(BUCKET_WIDTH_US + 1);

  // register reset values
  localparam logic [LAT_W-1:0] THRESH_RST  = LAT_W'(1000);
  localparam logic [PM_W-1:0]  PM_LOW_RST  = PM_W'(500);
  localparam logic [PM_W-1:0]  PM_MID_RST  = PM_W'(990);
  localparam logic [PM_W-1:0]  PM_HIGH_RST = PM_W'(999);

  // register indexes
  localparam logic [CFG_AW-1:0] CFG_THRESH  = CFG_AW'(0);
  localparam logic [CFG_AW-1:0] CFG_PM_LOW  = CFG_AW'(1);
  localparam logic [CFG_AW-1:0] CFG_PM_MID  = CFG_AW'(2);
  localparam logic [CFG_AW-1:0] CFG_PM_HIGH = CFG_AW'(3);

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    FN_RECORD   = 3'd0,
    FN_DEFERRED = 3'd1,
    FN_REPORT   = 3'd2,
    FN_CLEAR    = 3'd3,
    FN_DRAIN    = 3'd4
  } func_t;

  // result kinds
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_DRAIN  = 1'b1;

  // control of the accumulate and compare unit
  typedef struct packed {
    logic             load;
    logic             acc_en;
    logic             scaled;
    logic             cmp_en;
    logic [BKT_W-1:0] cmp_idx;
  } walk_ctl_t;

  // status of the accumulate and compare unit
  typedef struct packed {
    logic [CNT_W-1:0] sum;
    logic             hit;
    logic [BKT_W-1:0] hit_idx;
  } walk_sts_t;

  // upper edge of a bucket, cut to the percentile field
  function automatic logic [PCT_W-1:0] bucket_edge(input logic [BKT_W-1:0] idx);
    logic [EDGE_PW-1:0] prod;
    prod = (EDGE_PW'(idx) + EDGE_PW'(1)) * EDGE_PW'(BUCKET_WIDTH_US);
    return PCT_W'(prod);
  endfunction

endpackage

// ===== sv/lhp_ram.sv =====
// ----------------------------------------------------------------------------
// lhp_ram: bucket count memory
// one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module lhp_ram (
  input  logic                      clk,
  input  logic                      we,
  input  logic [lhp_pkg::BKT_W-1:0] waddr,
  input  logic [lhp_pkg::CNT_W-1:0] wdata,
  input  logic [lhp_pkg::BKT_W-1:0] raddr,
  output logic [lhp_pkg::CNT_W-1:0] rdata
);

  logic [lhp_pkg::CNT_W-1:0] mem [lhp_pkg::NUM_BUCKETS];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/lhp_walk.sv =====
// ----------------------------------------------------------------------------
// lhp_walk: shared accumulate and compare unit
// sums bucket counts, plain or scaled by the per mille base, and finds the
// first bucket where the scaled running sum reaches total times per mille
// ----------------------------------------------------------------------------
module lhp_walk (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lhp_pkg::walk_ctl_t        ctl,
  input  logic [lhp_pkg::CNT_W-1:0] total,
  input  logic [lhp_pkg::PM_W-1:0]  frac_pm,
  input  logic [lhp_pkg::CNT_W-1:0] rd_count,
  output lhp_pkg::walk_sts_t        sts
);

  logic [lhp_pkg::ACC_W-1:0] acc_r;
  logic [lhp_pkg::ACC_W-1:0] target_r;
  logic [lhp_pkg::ACC_W-1:0] addend;
  logic                      hit_r;
  logic [lhp_pkg::BKT_W-1:0] hit_idx_r;

  // operand select: raw count or count times the per mille base
  always_comb begin
    if (ctl.scaled) begin
      addend = lhp_pkg::ACC_W'(rd_count) * lhp_pkg::ACC_W'(lhp_pkg::PM_SCALE);
    end else begin
      addend = lhp_pkg::ACC_W'(rd_count);
    end
  end

  // accumulator, target and first hit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      hit_r     <= 1'b0;
      hit_idx_r <= lhp_pkg::BKT_W'(lhp_pkg::NUM_BUCKETS - 1);
    end else if (ctl.load) begin
      acc_r     <= '0;
      hit_r     <= 1'b0;
      hit_idx_r <= lhp_pkg::BKT_W'(lhp_pkg::NUM_BUCKETS - 1);
      target_r  <= lhp_pkg::ACC_W'(total) * lhp_pkg::ACC_W'(frac_pm);
    end else begin
      if (ctl.acc_en) begin
        acc_r <= acc_r + addend;
      end
      if (ctl.cmp_en && !hit_r && (acc_r >= target_r)) begin
        hit_r     <= 1'b1;
        hit_idx_r <= ctl.cmp_idx;
      end
    end
  end

  assign sts.sum     = acc_r[lhp_pkg::CNT_W-1:0];
  assign sts.hit     = hit_r;
  assign sts.hit_idx = hit_idx_r;

endmodule

// ===== sv/latency_histogram_percentiles.sv =====
// ----------------------------------------------------------------------------
// latency_histogram_percentiles: latency histogram with percentile report
// records samples into fixed width buckets, tracks maximum and outliers,
// and walks the buckets to report the total and three percentiles
// ----------------------------------------------------------------------------
//
// channel   dir   handshake          payload
// in_       in    tvalid / tready    tuser: func, tdata: lat_sample
// out_      out   tvalid / tready    tuser: result_kind, tdata: statistics
// cfg_      in    we                 addr: register index, wdata: value
//
// record steps through bucket index, memory read and read-modify-write;
// drain waits while a result is held; clear reruns the clearing pass.
// report walks the bucket memory once for the total and once per percentile
// through the single read port, or only for the total when it is zero.
// after reset a clearing pass zeroes every bucket, with in_tready low;
// configuration writes are taken during it.
// a waiting result does not block acceptance; only the next report or drain
// waits for the output register to free up.
// ----------------------------------------------------------------------------
module latency_histogram_percentiles (
  input  logic                       clk,
  input  logic                       rst_n,
  // in_tuser: func[2:0]
  input  logic [2:0]                 in_tuser,
  // in_tdata: lat_sample[31:0]
  input  logic [31:0]                in_tdata,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // out_tuser: result_kind[0]
  output logic [0:0]                 out_tuser,
  // out_tdata: sample_total[31:0], max_latency[63:32], deferred_total[95:64],
  // pct_low_us[108:96], pct_mid_us[121:109], pct_high_us[134:122],
  // outliers_found[135], outlier_count[167:136], outlier_max[199:168]
  output logic [199:0]               out_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic                       cfg_we,
  input  logic [lhp_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [31:0]                cfg_wdata
);

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_REC_IDX,
    ST_REC_RD,
    ST_REC_WR,
    ST_SETUP,
    ST_WALK,
    ST_RPT_OUT,
    ST_DRAIN_OUT
  } state_t;

  localparam logic [lhp_pkg::BKT_W-1:0] LAST_BKT = lhp_pkg::BKT_W'(lhp_pkg::NUM_BUCKETS - 1);

  state_t                      state_r;
  logic [lhp_pkg::BKT_W-1:0]   cnt_r;
  logic                        issue_done_r;
  logic                        v1_r;
  logic                        v2_r;
  logic [lhp_pkg::BKT_W-1:0]   idx1_r;
  logic [lhp_pkg::BKT_W-1:0]   idx2_r;
  logic [1:0]                  pass_r;

  logic [lhp_pkg::LAT_W-1:0]   thresh_r;
  logic [lhp_pkg::PM_W-1:0]    pm_low_r;
  logic [lhp_pkg::PM_W-1:0]    pm_mid_r;
  logic [lhp_pkg::PM_W-1:0]    pm_high_r;

  logic [lhp_pkg::CNT_W-1:0]   max_r;
  logic [lhp_pkg::CNT_W-1:0]   deferred_r;
  logic [lhp_pkg::CNT_W-1:0]   tally_r;
  logic [lhp_pkg::CNT_W-1:0]   peak_r;

  logic [lhp_pkg::LAT_W-1:0]   lat_r;
  logic [lhp_pkg::BKT_W-1:0]   bucket_r;
  logic [lhp_pkg::CNT_W-1:0]   total_r;
  logic [lhp_pkg::PCT_W-1:0]   pct_low_r;
  logic [lhp_pkg::PCT_W-1:0]   pct_mid_r;
  logic [lhp_pkg::PCT_W-1:0]   pct_high_r;

  logic                        out_valid_r;
  logic                        out_kind_r;
  logic [199:0]                out_data_r;

  logic                        in_fire;
  lhp_pkg::func_t              func;
  logic                        issuing;
  logic                        walk_end;
  logic                        slot_free;
  logic                        out_load;
  logic                        drain_found;
  logic [lhp_pkg::BKT_W-1:0]   bucket_calc;
  logic [lhp_pkg::LX_W+lhp_pkg::RSH:0] recip_prod;
  logic [lhp_pkg::PM_W-1:0]    pass_pm;
  logic [lhp_pkg::PCT_W-1:0]   hit_edge;

  logic                        ram_we;
  logic [lhp_pkg::BKT_W-1:0]   ram_waddr;
  logic [lhp_pkg::CNT_W-1:0]   ram_wdata;
  logic [lhp_pkg::BKT_W-1:0]   ram_raddr;
  logic [lhp_pkg::CNT_W-1:0]   ram_rdata;

  lhp_pkg::walk_ctl_t          wctl;
  lhp_pkg::walk_sts_t          wsts;

  // handshake
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign func      = lhp_pkg::func_t'(in_tuser);
  assign slot_free = !out_valid_r || out_tready;
  assign out_load  = slot_free && (state_r == ST_RPT_OUT || state_r == ST_DRAIN_OUT);

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = out_data_r;

  // bucket index: reciprocal multiply below the limit, last bucket above
  assign recip_prod = (lhp_pkg::LX_W+lhp_pkg::RSH+1)'(lat_r[lhp_pkg::LX_W-1:0]) *
                      (lhp_pkg::LX_W+lhp_pkg::RSH+1)'(lhp_pkg::RECIP);
  always_comb begin
    if (64'(lat_r) >= 64'(lhp_pkg::LAT_LIMIT)) begin
      bucket_calc = LAST_BKT;
    end else begin
      bucket_calc = recip_prod[lhp_pkg::RSH +: lhp_pkg::BKT_W];
    end
  end

  // walk sequencing
  assign issuing  = (state_r == ST_WALK) && !issue_done_r;
  assign walk_end = (state_r == ST_WALK) && issue_done_r && !v1_r && !v2_r;
  assign hit_edge = lhp_pkg::bucket_edge(wsts.hit_idx);
  assign drain_found = (tally_r != '0);

  // per mille of the current percentile pass
  always_comb begin
    case (pass_r)
      2'd1:    pass_pm = pm_low_r;
      2'd2:    pass_pm = pm_mid_r;
      2'd3:    pass_pm = pm_high_r;
      default: pass_pm = '0;
    endcase
  end

  // shared unit control
  always_comb begin
    wctl.load    = (state_r == ST_SETUP);
    wctl.acc_en  = v1_r;
    wctl.scaled  = (pass_r != 2'd0);
    wctl.cmp_en  = v2_r && (pass_r != 2'd0);
    wctl.cmp_idx = idx2_r;
  end

  // memory port select
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_r;
    ram_wdata = '0;
    ram_raddr = cnt_r;
    unique case (state_r)
      ST_CLR: begin
        ram_we = 1'b1;
      end
      ST_REC_RD: begin
        ram_raddr = bucket_r;
      end
      ST_REC_WR: begin
        ram_we    = 1'b1;
        ram_waddr = bucket_r;
        ram_wdata = ram_rdata + lhp_pkg::CNT_W'(1);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  lhp_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lhp_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (wctl),
    .total     (total_r),
    .frac_pm   (pass_pm),
    .rd_count  (ram_rdata),
    .sts       (wsts)
  );

  // sequencer, statistics registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLR;
      cnt_r        <= '0;
      issue_done_r <= 1'b0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      pass_r       <= 2'd0;
      thresh_r     <= lhp_pkg::THRESH_RST;
      pm_low_r     <= lhp_pkg::PM_LOW_RST;
      pm_mid_r     <= lhp_pkg::PM_MID_RST;
      pm_high_r    <= lhp_pkg::PM_HIGH_RST;
      max_r        <= '0;
      deferred_r   <= '0;
      tally_r      <= '0;
      peak_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      // read pipeline of the walk
      v1_r   <= issuing;
      idx1_r <= cnt_r;
      v2_r   <= v1_r;
      idx2_r <= idx1_r;

      // result loaded or taken
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      // configuration writes
      if (cfg_we) begin
        unique case (cfg_addr)
          lhp_pkg::CFG_THRESH:  thresh_r  <= cfg_wdata;
          lhp_pkg::CFG_PM_LOW:  pm_low_r  <= cfg_wdata[lhp_pkg::PM_W-1:0];
          lhp_pkg::CFG_PM_MID:  pm_mid_r  <= cfg_wdata[lhp_pkg::PM_W-1:0];
          lhp_pkg::CFG_PM_HIGH: pm_high_r <= cfg_wdata[lhp_pkg::PM_W-1:0];
          default: ;
        endcase
      end

      unique case (state_r)
        // zero the bucket memory one entry a cycle
        ST_CLR: begin
          if (cnt_r == LAST_BKT) begin
            state_r <= ST_IDLE;
          end else begin
            cnt_r <= cnt_r + lhp_pkg::BKT_W'(1);
          end
        end

        // take a transaction and dispatch
        ST_IDLE: begin
          if (in_fire) begin
            lat_r <= in_tdata;
            unique case (func)
              lhp_pkg::FN_RECORD: begin
                state_r <= ST_REC_IDX;
              end
              lhp_pkg::FN_DEFERRED: begin
                deferred_r <= deferred_r + lhp_pkg::CNT_W'(1);
              end
              lhp_pkg::FN_REPORT: begin
                pass_r     <= 2'd0;
                pct_low_r  <= '0;
                pct_mid_r  <= '0;
                pct_high_r <= '0;
                state_r    <= ST_SETUP;
              end
              lhp_pkg::FN_CLEAR: begin
                max_r      <= '0;
                deferred_r <= '0;
                tally_r    <= '0;
                peak_r     <= '0;
                cnt_r      <= '0;
                state_r    <= ST_CLR;
              end
              lhp_pkg::FN_DRAIN: begin
                state_r <= ST_DRAIN_OUT;
              end
              default: ;
            endcase
          end
        end

        // record: bucket index, then read, then write back
        ST_REC_IDX: begin
          bucket_r <= bucket_calc;
          state_r  <= ST_REC_RD;
        end
        ST_REC_RD: begin
          state_r <= ST_REC_WR;
        end
        ST_REC_WR: begin
          if (lat_r > max_r) begin
            max_r <= lat_r;
          end
          if (lat_r > thresh_r) begin
            tally_r <= tally_r + lhp_pkg::CNT_W'(1);
            if (lat_r > peak_r) begin
              peak_r <= lat_r;
            end
          end
          state_r <= ST_IDLE;
        end

        // start one pass over the buckets
        ST_SETUP: begin
          cnt_r        <= '0;
          issue_done_r <= 1'b0;
          state_r      <= ST_WALK;
        end

        // issue all bucket reads, then collect the pass result
        ST_WALK: begin
          if (issuing) begin
            if (cnt_r == LAST_BKT) begin
              issue_done_r <= 1'b1;
            end else begin
              cnt_r <= cnt_r + lhp_pkg::BKT_W'(1);
            end
          end
          if (walk_end) begin
            case (pass_r)
              2'd0: begin
                total_r <= wsts.sum;
                if (wsts.sum == '0) begin
                  state_r <= ST_RPT_OUT;
                end else begin
                  pass_r  <= 2'd1;
                  state_r <= ST_SETUP;
                end
              end
              2'd1: begin
                pct_low_r <= hit_edge;
                pass_r    <= 2'd2;
                state_r   <= ST_SETUP;
              end
              2'd2: begin
                pct_mid_r <= hit_edge;
                pass_r    <= 2'd3;
                state_r   <= ST_SETUP;
              end
              default: begin
                pct_high_r <= hit_edge;
                state_r    <= ST_RPT_OUT;
              end
            endcase
          end
        end

        // load the report once the output register is free
        ST_RPT_OUT: begin
          if (slot_free) begin
            out_kind_r  <= lhp_pkg::KIND_REPORT;
            out_data_r  <= {32'd0, 32'd0, 1'b0, pct_high_r, pct_mid_r, pct_low_r,
                            deferred_r, max_r, total_r};
            state_r     <= ST_IDLE;
          end
        end

        // load the drain answer and clear the outlier state
        ST_DRAIN_OUT: begin
          if (slot_free) begin
            out_kind_r  <= lhp_pkg::KIND_DRAIN;
            if (drain_found) begin
              out_data_r <= {peak_r, tally_r, 1'b1, 39'd0, 32'd0, 32'd0, 32'd0};
              peak_r     <= '0;
            end else begin
              out_data_r <= '0;
            end
            tally_r <= '0;
            state_r <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // no bucket read in flight while a transaction can be taken
  a_idle_pipe_empty : assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!v1_r && !v2_r))
    else $error("walk pipeline busy while accepting");

  // memory is written only by the clearing pass and the record write back
  a_ram_we_src : assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_CLR || state_r == ST_REC_WR))
    else $error("unexpected bucket memory write");

  // a new result appears only from a report or drain state
  a_out_src : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_RPT_OUT || $past(state_r) == ST_DRAIN_OUT))
    else $error("result loaded outside report or drain");

  // a report starts with the total pass
  a_report_start : assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && func == lhp_pkg::FN_REPORT) |=> (state_r == ST_SETUP && pass_r == 2'd0))
    else $error("report did not start with the total pass");

endmodule
